@@ rtl/sgb_pkg.sv @@
// Shared types, constants and arithmetic helpers of the separable Gaussian blur.
`timescale 1ns / 1ps
`default_nettype none
package sgb_pkg;

  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned AddrW    = $clog2(MaxWidth);

  localparam logic [11:0] ResetFrameWidth   = 12'd640;
  localparam logic [15:0] ResetFrameHeight  = 16'd480;
  localparam logic [15:0] ResetWeightCenter = 16'd40632;
  localparam logic [15:0] ResetWeightNear   = 16'd11796;
  localparam logic [15:0] ResetWeightFar    = 16'd655;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_WEIGHT_CENTER = 3'd2,
    CFG_WEIGHT_NEAR   = 3'd3,
    CFG_WEIGHT_FAR    = 3'd4
  } cfg_idx_e;

  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic [11:0] frame_width;
    logic [15:0] frame_height;
    logic [15:0] weight_center;
    logic [15:0] weight_near;
    logic [15:0] weight_far;
  } cfg_t;

  // One column operation of the vertical pass.
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             last;
    logic             drain;
    logic [AddrW-1:0] col;
    logic [15:0]      out_y;
    logic [1:0]       wslot;
    logic [4:0][1:0]  slot;
    pix_t [4:0]       tap;
  } op_t;

  function automatic logic [7:0] blur_ch(input logic [15:0] wc, input logic [15:0] wn,
                                         input logic [15:0] wf, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c,
                                         input logic [7:0] d, input logic [7:0] e);
    logic [8:0]  sa;
    logic [8:0]  sb;
    logic [24:0] m0;
    logic [24:0] m1;
    logic [24:0] m2;
    logic [26:0] s;
    sa = {1'b0, a} + {1'b0, e};
    sb = {1'b0, b} + {1'b0, d};
    m0 = 25'(wf) * 25'(sa);
    m1 = 25'(wn) * 25'(sb);
    m2 = 25'(wc) * 25'(c);
    s  = 27'(m0) + 27'(m1) + 27'(m2);
    return (s[26:24] != 3'd0) ? 8'hFF : s[23:16];
  endfunction

  function automatic pix_t blur_pix(input cfg_t cfg, input pix_t a, input pix_t b,
                                    input pix_t c, input pix_t d, input pix_t e);
    pix_t r;
    r = '0;
    for (int ch = 0; ch < 3; ch++) begin
      r[ch*8 +: 8] = blur_ch(cfg.weight_center, cfg.weight_near, cfg.weight_far,
                             a[ch*8 +: 8], b[ch*8 +: 8], c[ch*8 +: 8],
                             d[ch*8 +: 8], e[ch*8 +: 8]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/sgb_ifs.sv @@
// Stream and configuration channel interfaces of the blur block.
`timescale 1ns / 1ps
`default_nettype none
interface sgb_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  modport source(output valid, req_type, blue, green, red, input ready);
  modport sink(input valid, req_type, blue, green, red, output ready);
endinterface

interface sgb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  blue_out;
  logic [7:0]  green_out;
  logic [7:0]  red_out;
  logic [10:0] out_x;
  logic [15:0] out_y;
  logic        last;
  modport source(output valid, blue_out, green_out, red_out, out_x, out_y, last,
                 input ready);
  modport sink(input valid, blue_out, green_out, red_out, out_x, out_y, last,
               output ready);
endinterface

interface sgb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/sgb_ram.sv @@
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sgb_ram #(
  parameter int unsigned Width = 96,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/sgb_front.sv @@
// Input stage: frame counters, pixel window and column operation sequencer.
`timescale 1ns / 1ps
`default_nettype none
module sgb_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire sgb_pkg::cfg_t cfg_i,
  sgb_in_if.sink             pix_i,
  output sgb_pkg::op_t       op_o
);

  localparam int unsigned AW = sgb_pkg::AddrW;

  logic [AW-1:0]         cc_q, cc_d;
  logic [16:0]           rc_q, rc_d;
  sgb_pkg::pix_t [3:0]   win_q, win_d;
  logic [1:0]            pend_q, pend_d;
  logic [16:0]           pend_y_q, pend_y_d;
  logic [AW-1:0]         pend_x_q, pend_x_d;
  logic                  pend_drain_q, pend_drain_d;
  sgb_pkg::op_t          op_q, op_d;

  logic [11:0]           wid;
  logic [11:0]           wm1_w;
  logic [AW-1:0]         wm1;
  logic [15:0]           hgt;
  logic [16:0]           hgt2;
  logic                  wrap;
  logic [16:0]           y_eff;
  logic [AW-1:0]         cc_eff;
  logic [AW-1:0]         x;
  logic                  is_last;
  logic                  in_frame;
  logic                  acc;
  logic                  take;
  sgb_pkg::pix_t         p;
  sgb_pkg::pix_t [3:0]   w_eff;
  logic [16:0]           cur_y;
  logic [16:0]           y_next;
  logic [17:0]           t;
  logic [17:0]           hgt3;

  always_comb begin
    if (cfg_i.frame_width < 12'd3) begin
      wid = 12'd3;
    end else if (32'(cfg_i.frame_width) > sgb_pkg::MaxWidth) begin
      wid = 12'(sgb_pkg::MaxWidth);
    end else begin
      wid = cfg_i.frame_width;
    end
    hgt    = (cfg_i.frame_height < 16'd3) ? 16'd3 : cfg_i.frame_height;
    wm1_w  = wid - 12'd1;
    wm1    = wm1_w[AW-1:0];
    hgt2   = {1'b0, hgt} + 17'd2;
    hgt3   = {2'b0, hgt} + 18'd3;
    // A row count beyond the drain rows restarts the frame.
    wrap   = (rc_q >= hgt2);
    y_eff  = wrap ? '0 : rc_q;
    cc_eff = wrap ? '0 : cc_q;
    x      = (cc_eff >= wm1) ? wm1 : cc_eff;
    is_last  = (x == wm1);
    in_frame = (y_eff < {1'b0, hgt});
    y_next   = y_eff + 17'd1;
  end

  assign pix_i.ready = en_i && (pend_q == 2'd0);
  assign acc  = pix_i.valid && pix_i.ready;
  assign take = acc && (in_frame ? !pix_i.req_type : pix_i.req_type);
  assign p    = {pix_i.red, pix_i.green, pix_i.blue};
  assign w_eff = (x == '0) ? {4{p}} : win_q;
  assign cur_y = (pend_q != 2'd0) ? pend_y_q : y_eff;

  // Counters, window and pending column operations.
  always_comb begin
    cc_d         = cc_q;
    rc_d         = rc_q;
    win_d        = win_q;
    pend_d       = pend_q;
    pend_y_d     = pend_y_q;
    pend_x_d     = pend_x_q;
    pend_drain_d = pend_drain_q;
    if (en_i && (pend_q != 2'd0)) begin
      pend_d = pend_q - 2'd1;
    end
    if (acc) begin
      if (take) begin
        if (in_frame) begin
          win_d = {w_eff[2], w_eff[1], w_eff[0], p};
        end
        if (is_last) begin
          cc_d         = '0;
          rc_d         = (y_next >= hgt2) ? '0 : y_next;
          pend_d       = 2'd2;
          pend_y_d     = y_eff;
          pend_x_d     = x;
          pend_drain_d = !in_frame;
        end else begin
          cc_d = x + AW'(1);
        end
      end else if (wrap) begin
        cc_d = '0;
        rc_d = '0;
      end
    end
  end

  always_comb begin
    op_d       = '0;
    op_d.emit  = (cur_y >= 17'd2);
    op_d.out_y = 16'(cur_y - 17'd2);
    op_d.wslot = cur_y[1:0];
    for (int k = 0; k < 5; k++) begin
      t = 18'(cur_y) + 18'(k);
      if (t < 18'd4) begin
        op_d.slot[k] = 2'd0;
      end else if (t > hgt3) begin
        op_d.slot[k] = hgt[1:0] - 2'd1;
      end else begin
        op_d.slot[k] = t[1:0];
      end
    end
    if (pend_q != 2'd0) begin
      op_d.valid = 1'b1;
      op_d.drain = pend_drain_q;
      op_d.last  = (pend_q == 2'd1);
      if (pend_q == 2'd2) begin
        op_d.col = pend_x_q - AW'(1);
        op_d.tap = {win_q[0], win_q[0], win_q[1], win_q[2], win_q[3]};
      end else begin
        op_d.col = pend_x_q;
        op_d.tap = {win_q[0], win_q[0], win_q[0], win_q[1], win_q[2]};
      end
    end else begin
      op_d.valid = take && (x >= AW'(2));
      op_d.drain = !in_frame;
      op_d.last  = !is_last;
      op_d.col   = x - AW'(2);
      op_d.tap   = {p, w_eff[0], w_eff[1], w_eff[2], w_eff[3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q         <= '0;
      rc_q         <= '0;
      win_q        <= '0;
      pend_q       <= '0;
      pend_y_q     <= '0;
      pend_x_q     <= '0;
      pend_drain_q <= 1'b0;
      op_q         <= '0;
    end else if (en_i) begin
      cc_q         <= cc_d;
      rc_q         <= rc_d;
      win_q        <= win_d;
      pend_q       <= pend_d;
      pend_y_q     <= pend_y_d;
      pend_x_q     <= pend_x_d;
      pend_drain_q <= pend_drain_d;
      op_q         <= op_d;
    end
  end

  assign op_o = op_q;

endmodule
`default_nettype wire

@@ rtl/sgb_hpass.sv @@
// Horizontal pass: blurs the five row taps of each frame column operation.
`timescale 1ns / 1ps
`default_nettype none
module sgb_hpass (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire sgb_pkg::cfg_t cfg_i,
  input  wire sgb_pkg::op_t  op_i,
  output sgb_pkg::op_t       op_o
);

  sgb_pkg::op_t op_q, op_d;

  always_comb begin
    op_d = op_i;
    // The horizontal result takes the place of the newest vertical tap.
    op_d.tap[4] = sgb_pkg::blur_pix(cfg_i, op_i.tap[0], op_i.tap[1], op_i.tap[2],
                                    op_i.tap[3], op_i.tap[4]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
    end else if (en_i) begin
      op_q <= op_d;
    end
  end

  assign op_o = op_q;

endmodule
`default_nettype wire

@@ rtl/sgb_vpass.sv @@
// Vertical pass: row store write-back, column blur and the output register.
`timescale 1ns / 1ps
`default_nettype none
module sgb_vpass (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sgb_pkg::cfg_t                 cfg_i,
  input  wire sgb_pkg::op_t                  op_i,
  input  wire sgb_pkg::pix_t [3:0]           rdata_i,
  output logic                               en_o,
  output logic                               we_o,
  output logic [sgb_pkg::AddrW-1:0]          waddr_o,
  output sgb_pkg::pix_t [3:0]                wdata_o,
  sgb_out_if.source                          pix_o
);

  logic                        valid_q;
  sgb_pkg::pix_t               pix_q, pix_d;
  logic [sgb_pkg::AddrW-1:0]   x_q;
  logic [15:0]                 y_q;
  logic                        last_q;
  sgb_pkg::pix_t [4:0]         vt;

  assign en_o = !valid_q || pix_o.ready;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      vt[k] = rdata_i[op_i.slot[k]];
    end
    vt[4] = op_i.drain ? rdata_i[op_i.slot[4]] : op_i.tap[4];
    pix_d = sgb_pkg::blur_pix(cfg_i, vt[0], vt[1], vt[2], vt[3], vt[4]);
  end

  always_comb begin
    we_o    = en_o && op_i.valid && !op_i.drain;
    waddr_o = op_i.col;
    wdata_o = rdata_i;
    wdata_o[op_i.wslot] = op_i.tap[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= op_i.valid && op_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      pix_q  <= pix_d;
      x_q    <= op_i.col;
      y_q    <= op_i.out_y;
      last_q <= op_i.last;
    end
  end

  assign pix_o.valid     = valid_q;
  assign pix_o.blue_out  = pix_q[7:0];
  assign pix_o.green_out = pix_q[15:8];
  assign pix_o.red_out   = pix_q[23:16];
  assign pix_o.out_x     = 11'(x_q);
  assign pix_o.out_y     = y_q;
  assign pix_o.last      = last_q;

endmodule
`default_nettype wire

@@ rtl/separable_gaussian_blur_5tap.sv @@
// Top level of the streaming 5x5 separable Gaussian blur.
// Pixels enter on pix_i in raster order (req_type 0); after the frame the
// source sends 2*width drain transactions (req_type 1) that flush the bottom
// two rows. Results leave on pix_o with their column, row and a last flag
// on the final result of each input transaction. Registers are written on
// cfg_i (index 0 width, 1 height, 2..4 center, near and far weights); the
// user must write them only while the block is idle, which the block does not
// enforce. cfg_i is always ready. Throughput is one input transaction per
// cycle; when the receiver stalls, the whole pipeline holds and pix_i drops
// ready. An input in the last column gives three results and holds pix_i off
// until its pending operations issue, since the column store takes one column
// read-modify-write per cycle. A result passes the operation register, the
// horizontal pass with the store read, then the vertical pass into the output
// register. After reset the counters are zero, the window is cleared and the
// registers hold their default values; the column store needs no clearing,
// since every read entry of a frame was written earlier in it.
`timescale 1ns / 1ps
`default_nettype none
module separable_gaussian_blur_5tap (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sgb_cfg_if.sink    cfg_i,
  sgb_in_if.sink     pix_i,
  sgb_out_if.source  pix_o
);

  sgb_pkg::cfg_t             cfg_q, cfg_d;
  logic                      en;
  sgb_pkg::op_t              op_f;
  sgb_pkg::op_t              op_h;
  sgb_pkg::pix_t [3:0]       rdata;
  logic                      we;
  logic [sgb_pkg::AddrW-1:0] waddr;
  sgb_pkg::pix_t [3:0]       wdata;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (sgb_pkg::cfg_idx_e'(cfg_i.index))
        sgb_pkg::CFG_FRAME_WIDTH:   cfg_d.frame_width   = cfg_i.data[11:0];
        sgb_pkg::CFG_FRAME_HEIGHT:  cfg_d.frame_height  = cfg_i.data;
        sgb_pkg::CFG_WEIGHT_CENTER: cfg_d.weight_center = cfg_i.data;
        sgb_pkg::CFG_WEIGHT_NEAR:   cfg_d.weight_near   = cfg_i.data;
        sgb_pkg::CFG_WEIGHT_FAR:    cfg_d.weight_far    = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= sgb_pkg::ResetFrameWidth;
      cfg_q.frame_height  <= sgb_pkg::ResetFrameHeight;
      cfg_q.weight_center <= sgb_pkg::ResetWeightCenter;
      cfg_q.weight_near   <= sgb_pkg::ResetWeightNear;
      cfg_q.weight_far    <= sgb_pkg::ResetWeightFar;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sgb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .pix_i  (pix_i),
    .op_o   (op_f)
  );

  sgb_hpass u_hpass (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .op_i   (op_f),
    .op_o   (op_h)
  );

  // Each entry holds one column of the four most recent rows.
  sgb_ram #(
    .Width (96),
    .Depth (sgb_pkg::MaxWidth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (en),
    .raddr_i (op_f.col),
    .rdata_o (rdata)
  );

  sgb_vpass u_vpass (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .op_i    (op_h),
    .rdata_i (rdata),
    .en_o    (en),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .pix_o   (pix_o)
  );

endmodule
`default_nettype wire
